// ===== hw/rtl/nfia_pkg.sv =====
package nfia_pkg;

   // Sizing
   localparam int NUM_IDS_DEFAULT = 4096;
   localparam int ID_W            = 16;
   localparam int WORD_W          = 32;
   localparam int BIT_W           = 5;
   localparam int WIDE_W          = ID_W + 1;

   localparam logic [ID_W-1:0] ID_BASE_RESET = 16'd300;

   // Request kinds
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_NOT_USED = 2'd3
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clr_write;
      logic load_req;
      logic res_full;
      logic scan_start;
      logic rd_rel;
      logic alloc_step;
      logic res_range;
      logic rel_step;
      logic post;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clr_last;
      logic op_release;
      logic full;
      logic range_bad;
      logic found;
   } stat_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } hit_type;

   // Lowest set bit of a map word
   function automatic hit_type first_free(input logic [WORD_W-1:0] avail);
      hit_type hit;
      hit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (avail[i]) begin
            hit.found = 1'b1;
            hit.idx   = BIT_W'(i);
         end
      end
      return hit;
   endfunction

endpackage

// ===== hw/rtl/nfia_chan_if.sv =====
interface nfia_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] release_id;

   modport source (output valid, output op, output release_id, input ready);
   modport sink   (input valid, input op, input release_id, output ready);
endinterface

interface nfia_rsp_if;
   logic                valid;
   logic                ready;
   nfia_pkg::status_type status;
   logic [15:0]         granted_id;

   modport source (output valid, output status, output granted_id, input ready);
   modport sink   (input valid, input status, input granted_id, output ready);
endinterface

interface nfia_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] id_base;

   modport source (output valid, output id_base, input ready);
   modport sink   (input valid, input id_base, output ready);
endinterface

// ===== hw/rtl/nfia_ctrl.sv =====
module nfia_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  nfia_pkg::stat_type stat,
   output nfia_pkg::cmd_type  cmd
);
   import nfia_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ALLOC_RD,
      ST_ALLOC_CHK,
      ST_REL_CHK,
      ST_REL_UPD,
      ST_POST
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Sequence one item at a time
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.op_release) begin
               state_in = ST_REL_CHK;
            end else if (stat.full) begin
               cmd.res_full = 1'b1;
               state_in     = ST_POST;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_ALLOC_RD;
            end
         end
         ST_ALLOC_RD: begin
            state_in = ST_ALLOC_CHK;
         end
         ST_ALLOC_CHK: begin
            cmd.alloc_step = 1'b1;
            state_in       = stat.found ? ST_POST : ST_ALLOC_RD;
         end
         ST_REL_CHK: begin
            if (stat.range_bad) begin
               cmd.res_range = 1'b1;
               state_in      = ST_POST;
            end else begin
               cmd.rd_rel = 1'b1;
               state_in   = ST_REL_UPD;
            end
         end
         ST_REL_UPD: begin
            cmd.rel_step = 1'b1;
            state_in     = ST_POST;
         end
         ST_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.post     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/nfia_dpath.sv =====
module nfia_dpath #(
   parameter int NUM_IDS = nfia_pkg::NUM_IDS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  nfia_pkg::cmd_type              cmd,
   output nfia_pkg::stat_type             stat,
   input  logic                           req_op,
   input  logic [nfia_pkg::ID_W-1:0]      req_release_id,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nfia_pkg::ID_W-1:0]      csr_id_base,
   output nfia_pkg::status_type           rsp_status,
   output logic [nfia_pkg::ID_W-1:0]      rsp_granted_id
);
   import nfia_pkg::*;

   localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int IDX_W     = $clog2(NUM_IDS);
   localparam int CNT_W     = $clog2(NUM_IDS + 1);
   localparam int LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_W;

   localparam logic [WADDR_W-1:0] LAST_WORD    = WADDR_W'(NUM_WORDS - 1);
   localparam logic [WORD_W-1:0]  LAST_MASK    =
      (LAST_BITS == WORD_W) ? '1 : WORD_W'((64'd1 << LAST_BITS) - 64'd1);
   localparam logic [WIDE_W-1:0]  NUM_IDS_WIDE = WIDE_W'(NUM_IDS);
   localparam logic [WIDE_W-1:0]  LAST_IDX     = WIDE_W'(NUM_IDS - 1);
   localparam logic [CNT_W-1:0]   CNT_RESET    = CNT_W'(NUM_IDS);

   // Use map, one bit per entry, packed into words
   logic [WORD_W-1:0] map_mem [NUM_WORDS];

   logic [WADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic               req_op_ff, req_op_in;
   logic [ID_W-1:0]    req_id_ff, req_id_in;
   logic [ID_W-1:0]    id_base_ff, id_base_in;
   logic [IDX_W-1:0]   search_pos_ff, search_pos_in;
   logic [CNT_W-1:0]   free_count_ff, free_count_in;
   logic [WADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic               scan_first_ff, scan_first_in;
   logic [WORD_W-1:0]  rd_data_ff;
   status_type         res_status_ff, res_status_in;
   logic [ID_W-1:0]    res_id_ff, res_id_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;

   logic [WIDE_W-1:0]  pos_wide;
   logic [WADDR_W-1:0] start_word;
   logic [BIT_W-1:0]   start_bit;
   logic [WIDE_W-1:0]  rel_diff;
   logic               range_bad;
   logic [WADDR_W-1:0] rel_word;
   logic [BIT_W-1:0]   rel_bit;
   logic [WORD_W-1:0]  avail;
   hit_type            hit;
   logic [WIDE_W-1:0]  found_wide;
   logic [IDX_W-1:0]   next_pos;
   logic               bit_used;
   logic [WADDR_W-1:0] rd_addr;
   logic               wr_en;
   logic [WADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0]  wr_data;

   // Split search position and release index into word and bit
   assign pos_wide   = WIDE_W'(search_pos_ff);
   assign start_word = pos_wide[BIT_W +: WADDR_W];
   assign start_bit  = pos_wide[BIT_W-1:0];

   assign rel_diff  = {1'b0, req_id_ff} - {1'b0, id_base_ff};
   assign range_bad = rel_diff[WIDE_W-1] || (rel_diff >= NUM_IDS_WIDE);
   assign rel_word  = rel_diff[BIT_W +: WADDR_W];
   assign rel_bit   = rel_diff[BIT_W-1:0];
   assign bit_used  = rd_data_ff[rel_bit];

   // Free entries in the word just read: skip below the start on the first
   // visit, and past the end of the map in the last word
   assign avail = ~rd_data_ff
                  & (scan_first_ff ? ({WORD_W{1'b1}} << start_bit) : {WORD_W{1'b1}})
                  & ((scan_addr_ff == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}});
   assign hit        = first_free(avail);
   assign found_wide = (WIDE_W'(scan_addr_ff) << BIT_W) | WIDE_W'(hit.idx);
   assign next_pos   = (found_wide == LAST_IDX) ? '0 : IDX_W'(found_wide + WIDE_W'(1));

   assign rd_addr = cmd.rd_rel ? rel_word : scan_addr_ff;

   // Select the one write into the map
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = '0;
      if (cmd.clr_write) begin
         wr_en = 1'b1;
      end else if (cmd.alloc_step && hit.found) begin
         wr_en   = 1'b1;
         wr_addr = scan_addr_ff;
         wr_data = rd_data_ff | (WORD_W'(1) << hit.idx);
      end else if (cmd.rel_step && bit_used) begin
         wr_en   = 1'b1;
         wr_addr = rel_word;
         wr_data = rd_data_ff & ~(WORD_W'(1) << rel_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      rd_data_ff <= map_mem[rd_addr];
   end

   // Next values of the datapath registers
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      req_op_in     = req_op_ff;
      req_id_in     = req_id_ff;
      id_base_in    = id_base_ff;
      search_pos_in = search_pos_ff;
      free_count_in = free_count_ff;
      scan_addr_in  = scan_addr_ff;
      scan_first_in = scan_first_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;

      if (cmd.clr_write) clr_addr_in = clr_addr_ff + WADDR_W'(1);
      if (csr_valid) id_base_in = csr_id_base;
      if (cmd.load_req) begin
         req_op_in = req_op;
         req_id_in = req_release_id;
      end
      if (cmd.res_full) begin
         res_status_in = STATUS_FULL;
         res_id_in     = '0;
      end
      if (cmd.res_range) begin
         res_status_in = STATUS_RANGE;
         res_id_in     = '0;
      end
      if (cmd.scan_start) begin
         scan_addr_in  = start_word;
         scan_first_in = 1'b1;
      end
      if (cmd.alloc_step) begin
         if (hit.found) begin
            search_pos_in = next_pos;
            free_count_in = free_count_ff - CNT_W'(1);
            res_status_in = STATUS_OK;
            res_id_in     = id_base_ff + ID_W'(found_wide);
         end else begin
            scan_addr_in  = (scan_addr_ff == LAST_WORD) ? '0 : scan_addr_ff + WADDR_W'(1);
            scan_first_in = 1'b0;
         end
      end
      if (cmd.rel_step) begin
         res_id_in = '0;
         if (bit_used) begin
            free_count_in = free_count_ff + CNT_W'(1);
            res_status_in = STATUS_OK;
         end else begin
            res_status_in = STATUS_NOT_USED;
         end
      end
      if (cmd.post) begin
         rsp_status_in = res_status_ff;
         rsp_id_in     = res_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         id_base_ff    <= ID_BASE_RESET;
         search_pos_ff <= '0;
         free_count_ff <= CNT_RESET;
      end else begin
         clr_addr_ff   <= clr_addr_in;
         id_base_ff    <= id_base_in;
         search_pos_ff <= search_pos_in;
         free_count_ff <= free_count_in;
      end
      req_op_ff     <= req_op_in;
      req_id_ff     <= req_id_in;
      scan_addr_ff  <= scan_addr_in;
      scan_first_ff <= scan_first_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign stat.clr_last   = (clr_addr_ff == LAST_WORD);
   assign stat.op_release = (req_op_ff == OP_RELEASE);
   assign stat.full       = (free_count_ff == '0);
   assign stat.range_bad  = range_bad;
   assign stat.found      = hit.found;

   assign csr_ready      = 1'b1;
   assign rsp_status     = rsp_status_ff;
   assign rsp_granted_id = rsp_id_ff;

endmodule

// ===== hw/rtl/next_fit_id_allocator_unit.sv =====
// Items are handled one at a time: a new request is accepted only in idle, after the result of
// the last one is posted. Release checks the range and, when in range, reads and updates one map
// word; allocate reads and checks map words in a loop until a free entry is found, and a full
// allocate goes straight to its result. A result still held on the output stalls the next post.
// Reset is synchronous; after reset the map is cleared one 32-entry word per cycle
// and no item is accepted until that is done.
module next_fit_id_allocator_unit #(
   parameter int NUM_IDS = nfia_pkg::NUM_IDS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   nfia_req_if.sink      req_chan,
   nfia_rsp_if.source    rsp_chan,
   nfia_csr_if.sink      csr_chan
);
   import nfia_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequence the work
   nfia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the map, counters and the result
   nfia_dpath #(
      .NUM_IDS (NUM_IDS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_chan.op),
      .req_release_id (req_chan.release_id),
      .csr_valid      (csr_chan.valid),
      .csr_ready      (csr_chan.ready),
      .csr_id_base    (csr_chan.id_base),
      .rsp_status     (rsp_chan.status),
      .rsp_granted_id (rsp_chan.granted_id)
   );

endmodule

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nfia_pkg::*;

   localparam int ID_COUNT = NUM_IDS_DEFAULT;

   typedef struct {
      status_type  status;
      logic [15:0] granted_id;
   } answer_type;

   logic clock = 1'b0;
   logic reset;

   nfia_req_if req_bus();
   nfia_rsp_if rsp_bus();
   nfia_csr_if csr_bus();

   next_fit_id_allocator_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #1 clock = ~clock;

   // Allocator state as the block should hold it after every accepted item
   bit          id_taken [ID_COUNT];
   int unsigned scan_pos;
   int unsigned free_left;
   logic [15:0] id_base_model;
   int          held_idx [$];

   answer_type  pending_answers [$];
   answer_type  due;
   int          error_count;
   bit          idling_on;
   int          rsp_hold_left;
   int          stall_left;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 100)
         $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic void clear_id_map();
      foreach (id_taken[i]) id_taken[i] = 1'b0;
      scan_pos      = 0;
      free_left     = ID_COUNT;
      id_base_model = ID_BASE_RESET;
      held_idx.delete();
   endfunction

   // Work out the answer to one request and advance the state
   function automatic answer_type predict_answer(input logic op, input logic [15:0] rel_id);
      answer_type  ans;
      int unsigned idx;
      ans.status     = STATUS_FULL;
      ans.granted_id = '0;
      if (op == OP_ALLOC) begin
         if (free_left == 0) return ans;
         idx = scan_pos;
         for (int n = 0; n < ID_COUNT; n++) begin
            if (!id_taken[idx]) begin
               id_taken[idx] = 1'b1;
               free_left--;
               scan_pos = (idx + 1 >= ID_COUNT) ? 0 : idx + 1;
               held_idx.push_back(idx);
               ans.status     = STATUS_OK;
               ans.granted_id = 16'(id_base_model + idx);
               return ans;
            end
            idx = (idx + 1 >= ID_COUNT) ? 0 : idx + 1;
         end
         return ans;
      end
      // release: range check without wrap, then use check
      if (rel_id < id_base_model) begin
         ans.status = STATUS_RANGE;
         return ans;
      end
      idx = rel_id - id_base_model;
      if (idx >= ID_COUNT) begin
         ans.status = STATUS_RANGE;
      end else if (!id_taken[idx]) begin
         ans.status = STATUS_NOT_USED;
      end else begin
         id_taken[idx] = 1'b0;
         free_left++;
         ans.status = STATUS_OK;
         for (int i = 0; i < held_idx.size(); i++) begin
            if (held_idx[i] == idx) begin
               held_idx.delete(i);
               break;
            end
         end
      end
      return ans;
   endfunction

   // Offer one item, hold it until taken, then record what should come back
   task automatic send_request(input logic op, input logic [15:0] rel_id);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.release_id <= rel_id;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      pending_answers.push_back(predict_answer(op, rel_id));
   endtask

   // Stop offering and wait until every expected item has come back
   task automatic drain_all();
      req_bus.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_id_base(input logic [15:0] value);
      csr_bus.valid   <= 1'b1;
      csr_bus.id_base <= value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      id_base_model = value;
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_held_id();
      int pos;
      pos = $urandom_range(0, held_idx.size() - 1);
      return 16'(id_base_model + held_idx[pos]);
   endfunction

   function automatic logic [15:0] noise_id();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'(id_base_model - 1);
         2: return 16'(id_base_model + ID_COUNT);
         default: return 16'(id_base_model + $urandom_range(0, ID_COUNT - 1));
      endcase
   endfunction

   // Grants, the range and not-used error codes, boundary identifiers and next-fit order
   task automatic test_directed();
      send_request(OP_ALLOC, 16'h0000);
      send_request(OP_ALLOC, 16'h0000);
      send_request(OP_ALLOC, 16'h0000);
      send_request(OP_RELEASE, 16'd301);
      send_request(OP_RELEASE, 16'd301);
      send_request(OP_RELEASE, 16'd299);
      send_request(OP_RELEASE, 16'd4396);
      send_request(OP_RELEASE, 16'd4395);
      send_request(OP_RELEASE, 16'h0000);
      send_request(OP_RELEASE, 16'hFFFF);
      send_request(OP_ALLOC, 16'h0000);
      send_request(OP_ALLOC, 16'hFFFF);
   endtask

   // Lowest and highest base, with the top identifier just past the range
   task automatic test_base_extremes();
      drain_all();
      write_id_base(16'd0);
      send_request(OP_RELEASE, 16'd0);
      send_request(OP_ALLOC, 16'h5A5A);
      send_request(OP_RELEASE, 16'hFFFF);
      drain_all();
      write_id_base(16'd61439);
      send_request(OP_ALLOC, 16'h0000);
      send_request(OP_RELEASE, 16'd65535);
      send_request(OP_RELEASE, 16'd65534);
      send_request(OP_RELEASE, 16'd61438);
      send_request(OP_RELEASE, 16'(id_base_model + scan_pos - 1));
   endtask

   // Free entries behind the search position and check they are passed over
   task automatic test_next_fit_order();
      drain_all();
      write_id_base(16'($urandom_range(0, 61439)));
      repeat (6) send_request(OP_ALLOC, 16'($urandom));
      send_request(OP_RELEASE, 16'(id_base_model + scan_pos - 2));
      send_request(OP_RELEASE, 16'(id_base_model + scan_pos - 5));
      send_request(OP_ALLOC, 16'h0000);
      send_request(OP_ALLOC, 16'h0000);
      send_request(OP_RELEASE, 16'(id_base_model + scan_pos - 1));
      send_request(OP_RELEASE, 16'(id_base_model + scan_pos - 1));
   endtask

   // Block the result side for a long stretch, then let it all drain
   task automatic test_backpressure();
      drain_all();
      rsp_hold_left = 400;
      repeat (40) begin
         if ($urandom_range(0, 1) == 0 || held_idx.size() == 0)
            send_request(OP_ALLOC, 16'($urandom));
         else
            send_request(OP_RELEASE, pick_held_id());
      end
      drain_all();
      repeat (10) send_request(OP_ALLOC, 16'($urandom));
   endtask

   task automatic test_random_traffic(input int count, input int alloc_pct);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < alloc_pct || held_idx.size() == 0)
            send_request(OP_ALLOC, 16'($urandom));
         else if (roll < 88)
            send_request(OP_RELEASE, pick_held_id());
         else
            send_request(OP_RELEASE, noise_id());
      end
   endtask

   // Result side: random stalls plus the long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each returned item with the oldest expectation
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("item with nothing expected", int'(rsp_bus.status), -1);
         end else begin
            due = pending_answers.pop_front();
            if (rsp_bus.status !== due.status)
               report_mismatch("status", int'(rsp_bus.status), int'(due.status));
            if (rsp_bus.granted_id !== due.granted_id)
               report_mismatch("granted_id", int'(rsp_bus.granted_id), int'(due.granted_id));
         end
      end
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_ALLOC;
      req_bus.release_id <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.id_base    <= '0;
      error_count   = 0;
      idling_on     = 1'b1;
      rsp_hold_left = 0;
      stall_left    = 0;
      clear_id_map();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_base_extremes();
      test_next_fit_order();
      test_backpressure();

      drain_all();
      write_id_base(16'($urandom_range(0, 61439)));
      test_random_traffic(300, 50);
      drain_all();
      write_id_base(16'd0);
      test_random_traffic(300, 75);
      drain_all();
      write_id_base(16'd61439);
      test_random_traffic(300, 45);
      drain_all();
      write_id_base(16'($urandom_range(0, 61439)));
      idling_on = 1'b0;
      test_random_traffic(300, 55);

      drain_all();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
